// ----- sv/mipsx_pkg.sv -----
// mipsx_pkg: shared types and constants of the mips subset executor
// holds instruction field codes, the decoded operation enum and the decode struct
// no dependencies
package mipsx_pkg;

  localparam int XLEN   = 32;
  localparam int REG_N  = 32;
  localparam int REG_AW = 5;

  // item kinds carried on the input tuser
  localparam logic [1:0] KIND_EXEC    = 2'd0;
  localparam logic [1:0] KIND_PRE_REG = 2'd1;
  localparam logic [1:0] KIND_PRE_MEM = 2'd2;

  // primary opcode and function codes
  localparam logic [5:0] OPC_RTYPE = 6'd0;
  localparam logic [5:0] OPC_LB    = 6'd32;
  localparam logic [5:0] OPC_SB    = 6'd40;
  localparam logic [5:0] FN_ADD    = 6'd32;
  localparam logic [5:0] FN_SUB    = 6'd34;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_PRE_REG,
    OP_PRE_MEM,
    OP_ADD,
    OP_SUB,
    OP_LB,
    OP_SB
  } exec_op_e;

  typedef struct packed {
    exec_op_e          op;
    logic [REG_AW-1:0] rs;
    logic [REG_AW-1:0] rt;
    logic [REG_AW-1:0] dest;
    logic              use_rs;
    logic              use_rt;
    logic              wr;
    logic [XLEN-1:0]   off;
  } dec_t;

endpackage

// ----- sv/mips_subset_instruction_executor.sv -----
// mips_subset_instruction_executor: top level, executes add, sub, lb and sb
// five-stage pipeline around a register file and a data memory
// depends on mipsx_pkg, mipsx_decode, mipsx_regfile, mipsx_dmem
//
// input stream s_axis: tuser carries the item kind (execute, preload register,
// preload memory word), tdata the instruction word, index and preload value.
// output stream m_axis: one result transaction per input transaction, in order.
// each transaction passes decode/register read, operand forward and add, a
// reciprocal multiply and a multiply by the depth for the address wrap, and
// memory access. throughput is one transaction per cycle while m_axis_tready
// is high and no load hazard holds stage 1. an instruction that needs a register
// still being loaded by an lb in flight waits until the lb reaches the output
// stage. after reset the register file and data memory are swept to zero, one
// word a cycle over max(MEM_DEPTH, 32) indexes, while s_axis_tready stays low.
// when m_axis_tready is low the result holds and earlier stages keep filling
// their empty slots; s_axis_tready drops only once the pipeline is full.
module mips_subset_instruction_executor #(
  parameter int MEM_DEPTH = 1024
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // instruction[31:0], load_index[41:32], load_value[73:42], zero[79:74]
  input  logic [79:0] s_axis_tdata,
  // opcode[1:0]
  input  logic [1:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // valid_instruction[0], reg_write[1], reg_index[6:2], reg_value[38:7],
  // mem_read[39], mem_write[40], mem_address[50:41], store_value[82:51], zero[87:83]
  output logic [87:0] m_axis_tdata
);

  localparam int AW    = $clog2(MEM_DEPTH);
  localparam int CLR_N = (MEM_DEPTH > 32) ? MEM_DEPTH : 32;
  localparam int CW    = $clog2(CLR_N);
  localparam logic [63:0] RECIP64 = 64'h1_0000_0000 / 64'(MEM_DEPTH);
  localparam logic [31:0] RECIP   = RECIP64[31:0];
  localparam logic [31:0] DEP32   = 32'(MEM_DEPTH);
  localparam logic [AW:0] DEP_R   = (AW+1)'(MEM_DEPTH);

  typedef struct packed {
    mipsx_pkg::exec_op_e op;
    logic                wr;
    logic [4:0]          dest;
    logic [31:0]         val;
    logic [31:0]         sum;
  } mid_t;

  typedef struct packed {
    mipsx_pkg::dec_t dec;
    logic [31:0]     lval;
    logic [9:0]      lidx;
  } s1_t;

  // clearing sweep
  logic          clr_busy_q, clr_busy_d;
  logic [CW-1:0] clr_cnt_q, clr_cnt_d;
  logic [31:0]   clr_cnt_ext;

  // pipeline
  logic        s1_v_q, s1_v_d, s2_v_q, s2_v_d, s3_v_q, s3_v_d;
  logic        s4_v_q, s4_v_d, s5_v_q, s5_v_d;
  s1_t         s1_q, s1_d;
  mid_t        s2_q, s2_d, s3_q, s4_q, s5_q;
  logic [31:0] s3_quo_q, s3_quo_d;
  logic [31:0] s4_qd_q, s4_qd_d;
  logic [AW-1:0] s5_addr_q, s5_addr_d;

  logic rdy1, rdy2, rdy3, rdy4, rdy5;
  logic s1_mv, s4_mv, s5_go, hazard, in_acc;

  mipsx_pkg::dec_t dec;
  logic [31:0] rf_a, rf_b, fw_a, fw_b, s5_wval, dm_rdata;
  logic [4:0]  raddr_a, raddr_b, rf_waddr;
  logic        rf_we;
  logic [31:0] rf_wdata;
  logic [63:0] prod2;
  logic [31:0] rem4;
  logic [AW:0] rr4, mod4;
  logic        dm_en, dm_we;
  logic [AW-1:0] dm_addr;
  logic [31:0] dm_wdata;

  // result fields
  logic        o_valid, o_rw, o_mr, o_mw;
  logic [4:0]  o_ridx;
  logic [31:0] o_rval, o_sval, o_addr_ext;

  mipsx_decode u_decode (
    .kind_i        (s_axis_tuser),
    .instruction_i (s_axis_tdata[31:0]),
    .load_index_i  (s_axis_tdata[41:32]),
    .dec_o         (dec)
  );

  // handshake chain, each stage fills when the next one frees up
  assign rdy5   = !s5_v_q || m_axis_tready;
  assign s5_go  = s5_v_q && m_axis_tready;
  assign rdy4   = !s4_v_q || rdy5;
  assign s4_mv  = s4_v_q && rdy5;
  assign rdy3   = !s3_v_q || rdy4;
  assign rdy2   = !s2_v_q || rdy3;
  assign s1_mv  = s1_v_q && rdy2 && !hazard;
  assign rdy1   = !s1_v_q || s1_mv;
  assign s_axis_tready = !clr_busy_q && rdy1;
  assign in_acc = s_axis_tvalid && s_axis_tready;

  // load data is not known before it reaches the output stage
  always_comb begin
    hazard = 1'b0;
    if (s1_v_q) begin
      if (s2_v_q && s2_q.op == mipsx_pkg::OP_LB &&
          ((s1_q.dec.use_rs && s2_q.dest == s1_q.dec.rs) ||
           (s1_q.dec.use_rt && s2_q.dest == s1_q.dec.rt))) begin
        hazard = 1'b1;
      end
      if (s3_v_q && s3_q.op == mipsx_pkg::OP_LB &&
          ((s1_q.dec.use_rs && s3_q.dest == s1_q.dec.rs) ||
           (s1_q.dec.use_rt && s3_q.dest == s1_q.dec.rt))) begin
        hazard = 1'b1;
      end
      if (s4_v_q && s4_q.op == mipsx_pkg::OP_LB &&
          ((s1_q.dec.use_rs && s4_q.dest == s1_q.dec.rs) ||
           (s1_q.dec.use_rt && s4_q.dest == s1_q.dec.rt))) begin
        hazard = 1'b1;
      end
    end
  end

  // register file, read again every cycle while stage 1 holds
  assign raddr_a = in_acc ? dec.rs : s1_q.dec.rs;
  assign raddr_b = in_acc ? dec.rt : s1_q.dec.rt;
  assign s5_wval = (s5_q.op == mipsx_pkg::OP_LB) ? dm_rdata : s5_q.val;

  always_comb begin
    clr_cnt_ext = 32'(clr_cnt_q);
    if (clr_busy_q) begin
      rf_we    = clr_cnt_ext < 32'd32;
      rf_waddr = clr_cnt_q[4:0];
      rf_wdata = '0;
    end else begin
      rf_we    = s5_go && s5_q.wr;
      rf_waddr = s5_q.dest;
      rf_wdata = s5_wval;
    end
  end

  mipsx_regfile u_regfile (
    .clk_i     (clk_i),
    .raddr_a_i (raddr_a),
    .raddr_b_i (raddr_b),
    .rdata_a_o (rf_a),
    .rdata_b_o (rf_b),
    .we_i      (rf_we),
    .waddr_i   (rf_waddr),
    .wdata_i   (rf_wdata)
  );

  // operand forwarding, youngest writer wins
  always_comb begin
    fw_a = rf_a;
    fw_b = rf_b;
    if (s5_v_q && s5_q.wr && s5_q.dest == s1_q.dec.rs) fw_a = s5_wval;
    if (s5_v_q && s5_q.wr && s5_q.dest == s1_q.dec.rt) fw_b = s5_wval;
    if (s4_v_q && s4_q.wr && s4_q.dest == s1_q.dec.rs) fw_a = s4_q.val;
    if (s4_v_q && s4_q.wr && s4_q.dest == s1_q.dec.rt) fw_b = s4_q.val;
    if (s3_v_q && s3_q.wr && s3_q.dest == s1_q.dec.rs) fw_a = s3_q.val;
    if (s3_v_q && s3_q.wr && s3_q.dest == s1_q.dec.rt) fw_b = s3_q.val;
    if (s2_v_q && s2_q.wr && s2_q.dest == s1_q.dec.rs) fw_a = s2_q.val;
    if (s2_v_q && s2_q.wr && s2_q.dest == s1_q.dec.rt) fw_b = s2_q.val;
  end

  // stage 1: execute add/sub, form the address sum, pass preload index and value
  always_comb begin
    s1_d.dec  = dec;
    s1_d.lval = s_axis_tdata[73:42];
    s1_d.lidx = s_axis_tdata[41:32];
    s2_d      = '0;
    s2_d.op   = s1_q.dec.op;
    s2_d.wr   = s1_q.dec.wr;
    s2_d.dest = s1_q.dec.dest;
    case (s1_q.dec.op)
      mipsx_pkg::OP_ADD:     s2_d.val = fw_a + fw_b;
      mipsx_pkg::OP_SUB:     s2_d.val = fw_a - fw_b;
      mipsx_pkg::OP_LB:      s2_d.sum = fw_a + s1_q.dec.off;
      mipsx_pkg::OP_SB: begin
        s2_d.sum = fw_a + s1_q.dec.off;
        s2_d.val = fw_b;
      end
      mipsx_pkg::OP_PRE_REG: s2_d.val = s1_q.lval;
      mipsx_pkg::OP_PRE_MEM: begin
        s2_d.sum = 32'(s1_q.lidx);
        s2_d.val = s1_q.lval;
      end
      default:               s2_d.val = '0;
    endcase
  end

  // stages 2..4: sum mod MEM_DEPTH via reciprocal, quotient low by at most one
  assign prod2    = {32'd0, s2_q.sum} * {32'd0, RECIP};
  assign s3_quo_d = prod2[63:32];
  assign s4_qd_d  = s3_quo_q * DEP32;
  assign rem4     = s4_q.sum - s4_qd_q;
  assign rr4      = rem4[AW:0];
  assign mod4     = (rr4 >= DEP_R) ? (rr4 - DEP_R) : rr4;
  assign s5_addr_d = mod4[AW-1:0];

  // data memory port: clearing sweep or stage 4 access
  always_comb begin
    if (clr_busy_q) begin
      dm_en    = clr_cnt_ext < 32'(MEM_DEPTH);
      dm_we    = 1'b1;
      dm_addr  = clr_cnt_q[AW-1:0];
      dm_wdata = '0;
    end else begin
      dm_en    = s4_mv && (s4_q.op inside {mipsx_pkg::OP_LB, mipsx_pkg::OP_SB,
                                           mipsx_pkg::OP_PRE_MEM});
      dm_we    = s4_q.op inside {mipsx_pkg::OP_SB, mipsx_pkg::OP_PRE_MEM};
      dm_addr  = s5_addr_d;
      dm_wdata = s4_q.val;
    end
  end

  mipsx_dmem #(
    .DEPTH (MEM_DEPTH),
    .AW    (AW)
  ) u_dmem (
    .clk_i   (clk_i),
    .en_i    (dm_en),
    .we_i    (dm_we),
    .addr_i  (dm_addr),
    .wdata_i (dm_wdata),
    .rdata_o (dm_rdata)
  );

  // valid bits and sweep control
  always_comb begin
    s1_v_d = rdy1 ? in_acc : s1_v_q;
    s2_v_d = rdy2 ? s1_mv  : s2_v_q;
    s3_v_d = rdy3 ? s2_v_q : s3_v_q;
    s4_v_d = rdy4 ? s3_v_q : s4_v_q;
    s5_v_d = rdy5 ? s4_v_q : s5_v_q;
    clr_cnt_d  = clr_cnt_q;
    clr_busy_d = clr_busy_q;
    if (clr_busy_q) begin
      clr_cnt_d = clr_cnt_q + 1'b1;
      if (clr_cnt_ext == 32'(CLR_N - 1)) begin
        clr_busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q     <= 1'b0;
      s2_v_q     <= 1'b0;
      s3_v_q     <= 1'b0;
      s4_v_q     <= 1'b0;
      s5_v_q     <= 1'b0;
      clr_busy_q <= 1'b1;
      clr_cnt_q  <= '0;
    end else begin
      s1_v_q     <= s1_v_d;
      s2_v_q     <= s2_v_d;
      s3_v_q     <= s3_v_d;
      s4_v_q     <= s4_v_d;
      s5_v_q     <= s5_v_d;
      clr_busy_q <= clr_busy_d;
      clr_cnt_q  <= clr_cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_q <= s1_d;
    end
    if (s1_mv) begin
      s2_q <= s2_d;
    end
    if (s2_v_q && rdy3) begin
      s3_q     <= s2_q;
      s3_quo_q <= s3_quo_d;
    end
    if (s3_v_q && rdy4) begin
      s4_q    <= s3_q;
      s4_qd_q <= s4_qd_d;
    end
    if (s4_mv) begin
      s5_q      <= s4_q;
      s5_addr_q <= s5_addr_d;
    end
  end

  // result fields, zero for preloads and unsupported instructions
  always_comb begin
    o_valid    = 1'b0;
    o_rw       = 1'b0;
    o_mr       = 1'b0;
    o_mw       = 1'b0;
    o_ridx     = '0;
    o_rval     = '0;
    o_sval     = '0;
    o_addr_ext = '0;
    case (s5_q.op)
      mipsx_pkg::OP_ADD, mipsx_pkg::OP_SUB: begin
        o_valid = 1'b1;
        o_rw    = 1'b1;
        o_ridx  = s5_q.dest;
        o_rval  = s5_q.val;
      end
      mipsx_pkg::OP_LB: begin
        o_valid    = 1'b1;
        o_rw       = 1'b1;
        o_mr       = 1'b1;
        o_ridx     = s5_q.dest;
        o_rval     = dm_rdata;
        o_addr_ext = 32'(s5_addr_q);
      end
      mipsx_pkg::OP_SB: begin
        o_valid    = 1'b1;
        o_mw       = 1'b1;
        o_sval     = s5_q.val;
        o_addr_ext = 32'(s5_addr_q);
      end
      default: begin
        o_valid = 1'b0;
      end
    endcase
  end

  assign m_axis_tvalid = s5_v_q;
  assign m_axis_tdata  = {5'd0, o_sval, o_addr_ext[9:0], o_mw, o_mr, o_rval, o_ridx,
                          o_rw, o_valid};

endmodule

// ----- sv/mipsx_decode.sv -----
// mipsx_decode: turns an input transaction into a decoded operation
// splits the instruction word into register fields and the sign-extended offset
// depends on mipsx_pkg
module mipsx_decode (
  input  logic [1:0]         kind_i,
  input  logic [31:0]        instruction_i,
  input  logic [9:0]         load_index_i,
  output mipsx_pkg::dec_t    dec_o
);

  logic [5:0] opc;
  logic [5:0] fn;

  assign opc = instruction_i[31:26];
  assign fn  = instruction_i[5:0];

  always_comb begin
    dec_o        = '0;
    dec_o.rs     = instruction_i[25:21];
    dec_o.rt     = instruction_i[20:16];
    dec_o.off    = {{16{instruction_i[15]}}, instruction_i[15:0]};
    dec_o.op     = mipsx_pkg::OP_NONE;
    case (kind_i)
      mipsx_pkg::KIND_EXEC: begin
        if (opc == mipsx_pkg::OPC_RTYPE && fn == mipsx_pkg::FN_ADD) begin
          dec_o.op   = mipsx_pkg::OP_ADD;
          dec_o.dest = instruction_i[15:11];
        end else if (opc == mipsx_pkg::OPC_RTYPE && fn == mipsx_pkg::FN_SUB) begin
          dec_o.op   = mipsx_pkg::OP_SUB;
          dec_o.dest = instruction_i[15:11];
        end else if (opc == mipsx_pkg::OPC_LB) begin
          dec_o.op   = mipsx_pkg::OP_LB;
          dec_o.dest = instruction_i[20:16];
        end else if (opc == mipsx_pkg::OPC_SB) begin
          dec_o.op   = mipsx_pkg::OP_SB;
        end
      end
      mipsx_pkg::KIND_PRE_REG: begin
        // indexes past the register file are dropped
        if (load_index_i[9:5] == 5'd0) begin
          dec_o.op   = mipsx_pkg::OP_PRE_REG;
          dec_o.dest = load_index_i[4:0];
        end
      end
      mipsx_pkg::KIND_PRE_MEM: begin
        dec_o.op = mipsx_pkg::OP_PRE_MEM;
      end
      default: begin
        dec_o.op = mipsx_pkg::OP_NONE;
      end
    endcase
    dec_o.use_rs = dec_o.op inside {mipsx_pkg::OP_ADD, mipsx_pkg::OP_SUB,
                                    mipsx_pkg::OP_LB, mipsx_pkg::OP_SB};
    dec_o.use_rt = dec_o.op inside {mipsx_pkg::OP_ADD, mipsx_pkg::OP_SUB,
                                    mipsx_pkg::OP_SB};
    dec_o.wr     = dec_o.op inside {mipsx_pkg::OP_ADD, mipsx_pkg::OP_SUB,
                                    mipsx_pkg::OP_LB, mipsx_pkg::OP_PRE_REG};
  end

endmodule

// ----- sv/mipsx_regfile.sv -----
// mipsx_regfile: 32 x 32 register file, two synchronous read ports, one write port
// a write to the address being read in the same cycle is passed to the read data
// depends on mipsx_pkg
module mipsx_regfile (
  input  logic                          clk_i,
  input  logic [mipsx_pkg::REG_AW-1:0]  raddr_a_i,
  input  logic [mipsx_pkg::REG_AW-1:0]  raddr_b_i,
  output logic [mipsx_pkg::XLEN-1:0]    rdata_a_o,
  output logic [mipsx_pkg::XLEN-1:0]    rdata_b_o,
  input  logic                          we_i,
  input  logic [mipsx_pkg::REG_AW-1:0]  waddr_i,
  input  logic [mipsx_pkg::XLEN-1:0]    wdata_i
);

  logic [mipsx_pkg::XLEN-1:0] regs [mipsx_pkg::REG_N];
  logic [mipsx_pkg::XLEN-1:0] rdata_a_q;
  logic [mipsx_pkg::XLEN-1:0] rdata_b_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      regs[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_a_q <= (we_i && waddr_i == raddr_a_i) ? wdata_i : regs[raddr_a_i];
    rdata_b_q <= (we_i && waddr_i == raddr_b_i) ? wdata_i : regs[raddr_b_i];
  end

  assign rdata_a_o = rdata_a_q;
  assign rdata_b_o = rdata_b_q;

endmodule

// ----- sv/mipsx_dmem.sv -----
// mipsx_dmem: single-port data memory with registered read data
// read data holds until the next read, so it can sit behind a stalled stage
// depends on mipsx_pkg
module mipsx_dmem #(
  parameter int DEPTH = 1024,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic                       clk_i,
  input  logic                       en_i,
  input  logic                       we_i,
  input  logic [AW-1:0]              addr_i,
  input  logic [mipsx_pkg::XLEN-1:0] wdata_i,
  output logic [mipsx_pkg::XLEN-1:0] rdata_o
);

  logic [mipsx_pkg::XLEN-1:0] mem [DEPTH];
  logic [mipsx_pkg::XLEN-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (we_i) begin
        mem[addr_i] <= wdata_i;
      end else begin
        rdata_q <= mem[addr_i];
      end
    end
  end

  assign rdata_o = rdata_q;

endmodule
